// ===== src/gbfit_pkg.sv =====
// ----------------------------------------------------------------------------
// Gated batch line fit: shared types and constants.
// Widths of the sample path, the running sums, the fit arithmetic and the
// structs that travel between the front, the snapshot queue and the back.
// ----------------------------------------------------------------------------
package gbfit_pkg;

	// Field widths of the sample and result words.
	localparam int SAMPLE_W = 20;
	localparam int COUNT_W  = 10;
	localparam int OUT_W    = 32;
	localparam int FRAC_W   = 16;

	// Widths of the running sums, sized so that a full batch cannot overflow.
	localparam int SUM_W = SAMPLE_W + COUNT_W;
	localparam int SQ_W  = 2 * SAMPLE_W + COUNT_W - 2;
	localparam int XY_W  = 2 * SAMPLE_W + COUNT_W;

	// Wide sums are multiplied by the count in two halves.
	localparam int SXX_LO_W = SQ_W / 2;
	localparam int SXY_LO_W = XY_W / 2;

	// Fit arithmetic widths.
	localparam int MUL_W  = ((OUT_W > SUM_W) ? OUT_W : SUM_W) + 1;
	localparam int NUM_W  = XY_W + COUNT_W;
	localparam int DEN_W  = COUNT_W + SQ_W;
	localparam int ICP_W  = OUT_W + SUM_W + 1;
	localparam int ACC_W  = ((NUM_W > ICP_W) ? NUM_W : ICP_W) + 1;
	localparam int DVD_W  = ((NUM_W + FRAC_W) > ICP_W) ? (NUM_W + FRAC_W) : ICP_W;
	localparam int DVS_W  = DEN_W;
	localparam int DIV_CNT_W = $clog2(DVD_W);

	// Snapshot queue between front and back.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = SAMPLE_W;

	localparam logic signed [SAMPLE_W-1:0] LOWER_RESET = '0;
	localparam logic signed [SAMPLE_W-1:0] UPPER_RESET = SAMPLE_W'(650 * 256);
	localparam logic [COUNT_W-1:0]         BATCH_RESET = COUNT_W'(140);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOWER = 2'd0,
		REG_UPPER = 2'd1,
		REG_BATCH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] lower;
		logic signed [SAMPLE_W-1:0] upper;
		logic [COUNT_W-1:0]         batch;
	} cfg_t;

	// Closed batch handed from the front to the back.
	typedef struct packed {
		logic [COUNT_W-1:0]       n;
		logic signed [SUM_W-1:0]  sx;
		logic signed [SUM_W-1:0]  sy;
		logic [SQ_W-1:0]          sxx;
		logic signed [XY_W-1:0]   sxy;
	} snap_t;

	// One finished fit.
	typedef struct packed {
		logic signed [OUT_W-1:0] slope;
		logic signed [OUT_W-1:0] intercept;
		logic                    fit_valid;
		logic [COUNT_W-1:0]      samples_used;
	} res_t;

	// Alignment of a partial product before it lands in the accumulator.
	typedef enum logic [1:0] {
		SH_NONE,
		SH_SQ,
		SH_XY
	} shift_t;

	typedef struct packed {
		logic   valid;
		logic   sub;
		shift_t shift;
	} pend_t;

	typedef enum logic [4:0] {
		BK_IDLE,
		BK_DEN_LO,
		BK_DEN_HI,
		BK_DEN_SQ,
		BK_DEN_END,
		BK_DEN_CHK,
		BK_NUM_LO,
		BK_NUM_HI,
		BK_NUM_XY,
		BK_NUM_END,
		BK_SLOPE_START,
		BK_SLOPE_DIV,
		BK_ICP_MUL,
		BK_ICP_END,
		BK_ICP_START,
		BK_ICP_DIV,
		BK_OUT
	} back_state_t;

endpackage

// ===== src/gated_batch_line_fit.sv =====
// Path: a word that closes a batch reaches its fit through the two front
// stages, the snapshot queue, the sequencer steps and the divider.
// Throughput: one word per cycle into the front while the four-entry batch
// queue has room for every word in flight; the back fits one batch at a time.
// Reset: asynchronous; clears sums, queue and output valid flag, restores
// the bounds and the batch size to their defaults.
// ----------------------------------------------------------------------------
// Gated batch line fit: top level.
// Least-squares line fit over batches of windowed position pairs, with a
// configuration port and a one-word result register on the output side.
// ----------------------------------------------------------------------------
module gated_batch_line_fit import gbfit_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        push,
	output logic                        full,
	input  logic signed [SAMPLE_W-1:0]  calc_position,
	input  logic signed [SAMPLE_W-1:0]  measured_position,
	output logic                        empty,
	input  logic                        pop,
	output logic signed [OUT_W-1:0]     slope,
	output logic signed [OUT_W-1:0]     intercept,
	output logic                        fit_valid,
	output logic [COUNT_W-1:0]          samples_used
);

	cfg_t               cfg_q;
	logic               snap_push;
	snap_t              snap_wdata;
	snap_t              snap_rdata;
	logic               snap_pop;
	logic               snap_empty;
	logic [Q_LVL_W-1:0] snap_level;
	logic               res_valid;
	logic               res_ready;
	res_t               res;
	res_t               out_q;
	logic               out_valid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lower <= LOWER_RESET;
			cfg_q.upper <= UPPER_RESET;
			cfg_q.batch <= BATCH_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_LOWER: cfg_q.lower <= $signed(cfg_data[SAMPLE_W-1:0]);
				REG_UPPER: cfg_q.upper <= $signed(cfg_data[SAMPLE_W-1:0]);
				REG_BATCH: cfg_q.batch <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	gbfit_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.push              (push),
		.calc_position     (calc_position),
		.measured_position (measured_position),
		.full              (full),
		.q_level           (snap_level),
		.snap_push         (snap_push),
		.snap_data         (snap_wdata)
	);

	gbfit_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (snap_push),
		.wr_data (snap_wdata),
		.rd_en   (snap_pop),
		.rd_data (snap_rdata),
		.q_empty (snap_empty),
		.level   (snap_level)
	);

	gbfit_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (snap_empty),
		.q_data    (snap_rdata),
		.q_pop     (snap_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output word register: refilled in the cycle the old word is taken.
	assign res_ready = !out_valid_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign empty        = !out_valid_q;
	assign slope        = out_q.slope;
	assign intercept    = out_q.intercept;
	assign fit_valid    = out_q.fit_valid;
	assign samples_used = out_q.samples_used;

endmodule

// ===== src/gbfit_div.sv =====
// ----------------------------------------------------------------------------
// Gated batch line fit: iterative divider.
// Restoring division of a signed dividend by a positive divisor, one quotient
// bit per cycle, truncated toward zero and saturated to the result width.
// ----------------------------------------------------------------------------
module gbfit_div import gbfit_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0]        divisor,
	output logic                    done,
	output logic signed [OUT_W-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;

	logic [DVS_W:0]       rem_sh;
	logic [DVS_W:0]       diff;
	logic                 ge;
	logic                 q_big;
	logic                 q_top;
	logic                 q_rest;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		rem_sh = {rem_q, dvd_q[DVD_W-1]};
		diff   = rem_sh - {1'b0, dvs_q};
		ge     = !diff[DVS_W];
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend register collects the quotient bits as it shifts.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DVD_W-1];
			dvd_q <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	// Apply the sign and clamp to the signed result range.
	always_comb begin
		q_big  = |dvd_q[DVD_W-1:OUT_W];
		q_top  = dvd_q[OUT_W-1];
		q_rest = |dvd_q[OUT_W-2:0];
		if (neg_q) begin
			if (q_big || (q_top && q_rest)) begin
				quotient = {1'b1, {(OUT_W-1){1'b0}}};
			end else begin
				quotient = -$signed(dvd_q[OUT_W-1:0]);
			end
		end else begin
			if (q_big || q_top) begin
				quotient = {1'b0, {(OUT_W-1){1'b1}}};
			end else begin
				quotient = $signed(dvd_q[OUT_W-1:0]);
			end
		end
	end

	assign done = done_q;

endmodule

// ===== src/gbfit_queue.sv =====
// ----------------------------------------------------------------------------
// Gated batch line fit: snapshot queue.
// A short first-in first-out buffer of closed batches between the
// accumulating front and the fitting back.
// ----------------------------------------------------------------------------
module gbfit_queue import gbfit_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  snap_t              wr_data,
	input  logic               rd_en,
	output snap_t              rd_data,
	output logic               q_empty,
	output logic [Q_LVL_W-1:0] level
);

	snap_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_LVL_W-1:0]  level_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				level_q <= level_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign q_empty = (level_q == '0);
	assign level   = level_q;

endmodule

// ===== src/gbfit_front.sv =====
// ----------------------------------------------------------------------------
// Gated batch line fit: front end.
// Gates each pair on the x window, forms x*x and x*y, accumulates the sums
// and hands a closed batch to the snapshot queue when the count is reached.
// ----------------------------------------------------------------------------
module gbfit_front import gbfit_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       push,
	input  logic signed [SAMPLE_W-1:0] calc_position,
	input  logic signed [SAMPLE_W-1:0] measured_position,
	output logic                       full,
	input  logic [Q_LVL_W-1:0]         q_level,
	output logic                       snap_push,
	output snap_t                      snap_data
);

	logic                         v_s1;
	logic signed [SAMPLE_W-1:0]   x_s1;
	logic signed [SAMPLE_W-1:0]   y_s1;
	logic                         v_s2;
	logic signed [SAMPLE_W-1:0]   x_s2;
	logic signed [SAMPLE_W-1:0]   y_s2;
	logic [2*SAMPLE_W-2:0]        xx_s2;
	logic signed [2*SAMPLE_W-1:0] xy_s2;

	logic [COUNT_W-1:0]      cnt_q;
	logic signed [SUM_W-1:0] sx_q;
	logic signed [SUM_W-1:0] sy_q;
	logic [SQ_W-1:0]         sxx_q;
	logic signed [XY_W-1:0]  sxy_q;

	logic                         in_window;
	logic                         take;
	logic [Q_LVL_W:0]             committed;
	logic signed [2*SAMPLE_W-1:0] xx_full;
	logic signed [2*SAMPLE_W-1:0] xy_full;
	logic [COUNT_W-1:0]           cnt_inc;
	logic                         fire;

	// Every word in flight may close a batch, so room is kept for each one.
	always_comb begin
		committed = (Q_LVL_W+1)'(q_level) + (Q_LVL_W+1)'(v_s1) + (Q_LVL_W+1)'(v_s2);
		full      = (committed >= (Q_LVL_W+1)'(Q_DEPTH));
		in_window = (calc_position > cfg.lower) && (calc_position < cfg.upper);
		take      = push && !full && in_window;
	end

	// Stage one: the pair that passed the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_s1 <= calc_position;
			y_s1 <= measured_position;
		end
	end

	// Stage two: products of the pair.
	always_comb begin
		xx_full = x_s1 * x_s1;
		xy_full = x_s1 * y_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			xx_s2 <= xx_full[2*SAMPLE_W-2:0];
			xy_s2 <= xy_full;
		end
	end

	// Accumulate, and close the batch once the count reaches the batch size.
	always_comb begin
		cnt_inc           = cnt_q + 1'b1;
		fire              = v_s2 && (cnt_inc >= cfg.batch);
		snap_push         = fire;
		snap_data.n       = cnt_inc;
		snap_data.sx      = sx_q + SUM_W'(x_s2);
		snap_data.sy      = sy_q + SUM_W'(y_s2);
		snap_data.sxx     = sxx_q + SQ_W'(xx_s2);
		snap_data.sxy     = sxy_q + XY_W'(xy_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			sxy_q <= '0;
		end else if (v_s2) begin
			if (fire) begin
				cnt_q <= '0;
				sx_q  <= '0;
				sy_q  <= '0;
				sxx_q <= '0;
				sxy_q <= '0;
			end else begin
				cnt_q <= snap_data.n;
				sx_q  <= snap_data.sx;
				sy_q  <= snap_data.sy;
				sxx_q <= snap_data.sxx;
				sxy_q <= snap_data.sxy;
			end
		end
	end

endmodule

// ===== src/gbfit_back.sv =====
// ----------------------------------------------------------------------------
// Gated batch line fit: back end.
// A sequencer with one shared multiplier and accumulator forms the denominator,
// then numerator and slope division if it is nonzero, and intercept division.
// ----------------------------------------------------------------------------
module gbfit_back import gbfit_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_empty,
	input  snap_t q_data,
	output logic  q_pop,
	output logic  res_valid,
	input  logic  res_ready,
	output res_t  res
);

	typedef enum logic [1:0] {
		ACC_RUN,
		ACC_CLEAR,
		ACC_LOAD_Y
	} acc_op_t;

	back_state_t state_q;
	back_state_t state_d;

	snap_t                     snap_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [2*MUL_W-1:0] prod_q;
	pend_t                     pend_q;
	logic [DEN_W-1:0]          den_q;
	logic                      valid_q;
	logic signed [OUT_W-1:0]   slope_q;
	logic signed [OUT_W-1:0]   icpt_q;

	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	pend_t                     pend_d;
	acc_op_t                   acc_op;
	logic                      den_load;
	logic                      slope_zero;
	logic                      slope_load;
	logic                      icpt_load;
	logic                      div_start;
	logic signed [DVD_W-1:0]   div_dividend;
	logic [DVS_W-1:0]          div_divisor;
	logic                      div_done;
	logic signed [OUT_W-1:0]   div_quotient;

	logic signed [ACC_W-1:0]          prod_lo;
	logic signed [ACC_W-1:0]          term;
	logic signed [ACC_W-1:0]          acc_next;
	logic signed [NUM_W+FRAC_W-1:0]   num_sh;
	logic signed [ICP_W-1:0]          icp_val;
	logic signed [MUL_W-1:0]          op_n;
	logic signed [MUL_W-1:0]          op_sx;

	// Operand forms used by several steps.
	always_comb begin
		op_n    = $signed({{(MUL_W-COUNT_W){1'b0}}, snap_q.n});
		op_sx   = $signed({{(MUL_W-SUM_W){snap_q.sx[SUM_W-1]}}, snap_q.sx});
		num_sh  = $signed({acc_q[NUM_W-1:0], {FRAC_W{1'b0}}});
		icp_val = $signed(acc_q[ICP_W-1:0]);
	end

	// The product from the last cycle lands in the accumulator, aligned.
	always_comb begin
		prod_lo = $signed(prod_q[ACC_W-1:0]);
		case (pend_q.shift)
			SH_NONE: term = prod_lo;
			SH_SQ:   term = prod_lo <<< SXX_LO_W;
			SH_XY:   term = prod_lo <<< SXY_LO_W;
			default: term = prod_lo;
		endcase
		if (!pend_q.valid) begin
			acc_next = acc_q;
		end else if (pend_q.sub) begin
			acc_next = acc_q - term;
		end else begin
			acc_next = acc_q + term;
		end
	end

	// Sequencer: next state, operand selection and strobes.
	always_comb begin
		state_d      = state_q;
		mul_a        = op_n;
		mul_b        = op_sx;
		pend_d       = '{valid: 1'b0, sub: 1'b0, shift: SH_NONE};
		acc_op       = ACC_RUN;
		q_pop        = 1'b0;
		den_load     = 1'b0;
		slope_zero   = 1'b0;
		slope_load   = 1'b0;
		icpt_load    = 1'b0;
		div_start    = 1'b0;
		div_dividend = DVD_W'(num_sh);
		div_divisor  = DVS_W'(den_q);
		res_valid    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				acc_op = ACC_CLEAR;
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = BK_DEN_LO;
				end
			end
			BK_DEN_LO: begin
				mul_b   = $signed({{(MUL_W-SXX_LO_W){1'b0}}, snap_q.sxx[SXX_LO_W-1:0]});
				pend_d  = '{valid: 1'b1, sub: 1'b0, shift: SH_NONE};
				state_d = BK_DEN_HI;
			end
			BK_DEN_HI: begin
				mul_b   = $signed({{(MUL_W-(SQ_W-SXX_LO_W)){1'b0}},
					snap_q.sxx[SQ_W-1:SXX_LO_W]});
				pend_d  = '{valid: 1'b1, sub: 1'b0, shift: SH_SQ};
				state_d = BK_DEN_SQ;
			end
			BK_DEN_SQ: begin
				mul_a   = op_sx;
				mul_b   = op_sx;
				pend_d  = '{valid: 1'b1, sub: 1'b1, shift: SH_NONE};
				state_d = BK_DEN_END;
			end
			BK_DEN_END: begin
				state_d = BK_DEN_CHK;
			end
			BK_DEN_CHK: begin
				den_load = 1'b1;
				acc_op   = ACC_CLEAR;
				if (acc_q != '0) begin
					state_d = BK_NUM_LO;
				end else begin
					slope_zero = 1'b1;
					state_d    = BK_ICP_MUL;
				end
			end
			BK_NUM_LO: begin
				mul_b   = $signed({{(MUL_W-SXY_LO_W){1'b0}}, snap_q.sxy[SXY_LO_W-1:0]});
				pend_d  = '{valid: 1'b1, sub: 1'b0, shift: SH_NONE};
				state_d = BK_NUM_HI;
			end
			BK_NUM_HI: begin
				mul_b   = $signed({{(MUL_W-(XY_W-SXY_LO_W)){snap_q.sxy[XY_W-1]}},
					snap_q.sxy[XY_W-1:SXY_LO_W]});
				pend_d  = '{valid: 1'b1, sub: 1'b0, shift: SH_XY};
				state_d = BK_NUM_XY;
			end
			BK_NUM_XY: begin
				mul_a   = op_sx;
				mul_b   = $signed({{(MUL_W-SUM_W){snap_q.sy[SUM_W-1]}}, snap_q.sy});
				pend_d  = '{valid: 1'b1, sub: 1'b1, shift: SH_NONE};
				state_d = BK_NUM_END;
			end
			BK_NUM_END: begin
				state_d = BK_SLOPE_START;
			end
			BK_SLOPE_START: begin
				div_start = 1'b1;
				state_d   = BK_SLOPE_DIV;
			end
			BK_SLOPE_DIV: begin
				if (div_done) begin
					slope_load = 1'b1;
					state_d    = BK_ICP_MUL;
				end
			end
			BK_ICP_MUL: begin
				// Start from Sy scaled by the slope fraction, then take off slope*Sx.
				mul_a   = $signed({{(MUL_W-OUT_W){slope_q[OUT_W-1]}}, slope_q});
				mul_b   = op_sx;
				pend_d  = '{valid: 1'b1, sub: 1'b1, shift: SH_NONE};
				acc_op  = ACC_LOAD_Y;
				state_d = BK_ICP_END;
			end
			BK_ICP_END: begin
				state_d = BK_ICP_START;
			end
			BK_ICP_START: begin
				div_start    = 1'b1;
				div_dividend = DVD_W'(icp_val);
				div_divisor  = DVS_W'({snap_q.n, {FRAC_W{1'b0}}});
				state_d      = BK_ICP_DIV;
			end
			BK_ICP_DIV: begin
				if (div_done) begin
					icpt_load = 1'b1;
					state_d   = BK_OUT;
				end
			end
			BK_OUT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// State and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			pend_q  <= '{valid: 1'b0, sub: 1'b0, shift: SH_NONE};
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	// Shared multiplier, accumulator and fit registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (acc_op)
			ACC_RUN:    acc_q <= acc_next;
			ACC_CLEAR:  acc_q <= '0;
			ACC_LOAD_Y: acc_q <= $signed({{(ACC_W-SUM_W-FRAC_W){snap_q.sy[SUM_W-1]}},
				snap_q.sy, {FRAC_W{1'b0}}});
			default:    acc_q <= acc_next;
		endcase
		if (q_pop) begin
			snap_q <= q_data;
		end
		if (den_load) begin
			den_q   <= acc_q[DEN_W-1:0];
			valid_q <= (acc_q != '0);
		end
		if (slope_zero) begin
			slope_q <= '0;
		end else if (slope_load) begin
			slope_q <= div_quotient;
		end
		if (icpt_load) begin
			icpt_q <= div_quotient;
		end
	end

	gbfit_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign res.slope        = slope_q;
	assign res.intercept    = icpt_q;
	assign res.fit_valid    = valid_q;
	assign res.samples_used = snap_q.n;

endmodule
